FILE: rtl/gtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtq_pkg
// Shared codes and state type for the grouped team queue.
// ----------------------------------------------------------------------------
package gtq_pkg;

	localparam int ACTION_W  = 2;
	localparam int TEAM_ID_W = 10;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 11;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ENQ = 2'd0,
		ACT_DEQ = 2'd1,
		ACT_CLR = 2'd2,
		ACT_NOP = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ENQ_RD,
		ST_ENQ_LINK,
		ST_ENQ_FIX,
		ST_ENQ_PUT,
		ST_DEQ_RD,
		ST_DEQ_TEAM,
		ST_DEQ_DONE
	} state_t;

endpackage

FILE: rtl/grouped_team_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_team_queue_core
// Team queue kept as a linked list of nodes in RAM, with per-team last-node
// pointers so an item joins behind its team without walking the list.
// ----------------------------------------------------------------------------
// Usage:
//   An item (action, item_value, team_id) is taken on a clock edge with start
//   high and busy low. Every item gives one result: done is high for exactly
//   one cycle with popped_value, status and occupancy valid in that cycle.
//   The receiver has no way to stall; a result must be taken when shown.
// Sequence (edge of acceptance to the done cycle):
//   an enqueue reads the free head and team entry, then the previous node,
//   relinks it (skipped when the queue is empty) and writes the new node; a
//   dequeue reads the head node, then its team entry. Full enqueue, empty
//   dequeue and the unused action are answered from idle. A new item can be
//   taken in the cycle showing the previous result, except for a clear.
//   Steps follow the dependent RAM reads and the node RAM's single write port.
// Reset and clear:
//   After reset, and after a clear item, busy stays high while the team table
//   is swept clean, one entry per cycle. The result of a clear is shown in
//   the first cycle of that sweep.
// ----------------------------------------------------------------------------
module grouped_team_queue_core #(
	parameter int CAPACITY   = 1024,
	parameter int TEAMS      = 1024,
	parameter int VALUE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [gtq_pkg::ACTION_W-1:0]      action,
	input  logic [VALUE_BITS-1:0]             item_value,
	input  logic [gtq_pkg::TEAM_ID_W-1:0]     team_id,
	output logic                              done,
	output logic [VALUE_BITS-1:0]             popped_value,
	output logic [gtq_pkg::STATUS_W-1:0]      status,
	output logic [gtq_pkg::OCC_W-1:0]         occupancy
);

	import gtq_pkg::*;

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int TI_W   = (TEAMS > 1) ? $clog2(TEAMS) : 1;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [TI_W-1:0]       team;
		logic [SLOT_W-1:0]     link;
	} node_t;

	typedef struct packed {
		logic              queued;
		logic [SLOT_W-1:0] last;
	} tent_t;

	localparam int NODE_W = $bits(node_t);
	localparam int TENT_W = $bits(tent_t);

	state_t state_q, state_d;

	logic [VALUE_BITS-1:0] value_q;
	logic [TI_W-1:0]       team_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SLOT_W-1:0]     prev_q;
	logic [SLOT_W-1:0]     link_q;
	logic                  queued_q;
	logic                  from_free_q;
	logic [SLOT_W-1:0]     head_q;
	logic [SLOT_W-1:0]     tail_q;
	logic [SLOT_W-1:0]     free_head_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      fresh_q;
	logic [TI_W-1:0]       sweep_q;

	logic                  done_q;
	logic [VALUE_BITS-1:0] popped_q;
	status_t               status_q;
	logic [CNT_W-1:0]      occ_q;

	logic                  node_we;
	logic [SLOT_W-1:0]     node_waddr;
	node_t                 node_wd;
	logic [SLOT_W-1:0]     node_raddr;
	logic [NODE_W-1:0]     node_rdata;
	node_t                 node_rd;

	logic                  team_we;
	logic [TI_W-1:0]       team_waddr;
	tent_t                 team_wd;
	logic [TI_W-1:0]       team_raddr;
	logic [TENT_W-1:0]     team_rdata;
	tent_t                 team_rd;

	logic [TEAM_ID_W-1:0]  team_rem;
	logic                  accept;
	action_t               act;
	logic                  free_any;
	logic [SLOT_W-1:0]     enq_prev;

	gtq_ram #(.WIDTH(NODE_W), .DEPTH(CAPACITY)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wd),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	gtq_ram #(.WIDTH(TENT_W), .DEPTH(TEAMS)) u_team_ram (
		.clk   (clk),
		.we    (team_we),
		.waddr (team_waddr),
		.wdata (team_wd),
		.raddr (team_raddr),
		.rdata (team_rdata)
	);

	assign node_rd = node_t'(node_rdata);
	assign team_rd = tent_t'(team_rdata);

	assign accept   = start && !busy;
	assign act      = action_t'(action);
	assign free_any = (fresh_q != count_q);
	assign enq_prev = team_rd.queued ? team_rd.last : tail_q;

	// team id wraps modulo TEAMS
	always_comb begin
		team_rem = team_id;
		for (int k = TEAM_ID_W - 1; k >= 0; k--) begin
			if (32'(team_rem) >= (32'(TEAMS) << k)) begin
				team_rem = team_rem - TEAM_ID_W'(32'(TEAMS) << k);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (sweep_q == TI_W'(TEAMS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					unique case (act)
						ACT_ENQ: if (count_q != CNT_W'(CAPACITY)) state_d = ST_ENQ_RD;
						ACT_DEQ: if (count_q != '0) state_d = ST_DEQ_RD;
						ACT_CLR: state_d = ST_SWEEP;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ENQ_RD:   state_d = ST_ENQ_LINK;
			ST_ENQ_LINK: begin
				if (!team_rd.queued && count_q == '0) begin
					state_d = ST_ENQ_PUT;
				end else begin
					state_d = ST_ENQ_FIX;
				end
			end
			ST_ENQ_FIX:  state_d = ST_ENQ_PUT;
			ST_ENQ_PUT:  state_d = ST_IDLE;
			ST_DEQ_RD:   state_d = ST_DEQ_TEAM;
			ST_DEQ_TEAM: state_d = ST_DEQ_DONE;
			ST_DEQ_DONE: state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		node_we    = 1'b0;
		node_waddr = slot_q;
		node_wd    = '0;
		node_raddr = head_q;
		team_we    = 1'b0;
		team_waddr = team_q;
		team_wd    = '0;
		team_raddr = team_q;
		busy       = (state_q != ST_IDLE);
		unique case (state_q)
			ST_SWEEP: begin
				team_we    = 1'b1;
				team_waddr = sweep_q;
			end
			ST_ENQ_RD: begin
				node_raddr = free_head_q;
			end
			ST_ENQ_LINK: begin
				node_raddr     = enq_prev;
				team_we        = 1'b1;
				team_wd.queued = 1'b1;
				team_wd.last   = slot_q;
			end
			ST_ENQ_FIX: begin
				node_we       = 1'b1;
				node_waddr    = prev_q;
				node_wd.value = node_rd.value;
				node_wd.team  = node_rd.team;
				node_wd.link  = slot_q;
			end
			ST_ENQ_PUT: begin
				node_we       = 1'b1;
				node_wd.value = value_q;
				node_wd.team  = team_q;
				node_wd.link  = link_q;
			end
			ST_DEQ_TEAM: begin
				team_raddr   = node_rd.team;
				node_we      = 1'b1;
				node_waddr   = head_q;
				node_wd.link = free_head_q;
			end
			ST_DEQ_DONE: begin
				if (team_rd.queued && team_rd.last == slot_q) begin
					team_we      = 1'b1;
					team_wd.last = team_rd.last;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			free_head_q <= '0;
			count_q     <= '0;
			fresh_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
				end
				ST_IDLE: begin
					if (accept) begin
						value_q  <= item_value;
						team_q   <= TI_W'(team_rem);
						popped_q <= '0;
						status_q <= STAT_DONE;
						occ_q    <= count_q;
						unique case (act)
							ACT_ENQ: begin
								if (count_q == CNT_W'(CAPACITY)) begin
									done_q   <= 1'b1;
									status_q <= STAT_FULL;
								end
							end
							ACT_DEQ: begin
								if (count_q == '0) begin
									done_q   <= 1'b1;
									status_q <= STAT_EMPTY;
								end
							end
							ACT_CLR: begin
								done_q  <= 1'b1;
								occ_q   <= '0;
								count_q <= '0;
								fresh_q <= '0;
								head_q  <= '0;
								tail_q  <= '0;
								sweep_q <= '0;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_ENQ_RD: begin
					from_free_q <= free_any;
					if (free_any) begin
						slot_q <= free_head_q;
					end else begin
						slot_q  <= fresh_q[SLOT_W-1:0];
						fresh_q <= fresh_q + 1'b1;
					end
				end
				ST_ENQ_LINK: begin
					if (from_free_q) begin
						free_head_q <= node_rd.link;
					end
					prev_q   <= enq_prev;
					queued_q <= team_rd.queued;
					link_q   <= '0;
					if (!team_rd.queued && count_q == '0) begin
						head_q <= slot_q;
						tail_q <= slot_q;
					end
				end
				ST_ENQ_FIX: begin
					link_q <= queued_q ? node_rd.link : '0;
					if (!queued_q || prev_q == tail_q) begin
						tail_q <= slot_q;
					end
				end
				ST_ENQ_PUT: begin
					count_q  <= count_q + 1'b1;
					done_q   <= 1'b1;
					popped_q <= '0;
					status_q <= STAT_DONE;
					occ_q    <= count_q + 1'b1;
				end
				ST_DEQ_TEAM: begin
					value_q     <= node_rd.value;
					team_q      <= node_rd.team;
					slot_q      <= head_q;
					free_head_q <= head_q;
					count_q     <= count_q - 1'b1;
					if (count_q == CNT_W'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						head_q <= node_rd.link;
					end
				end
				ST_DEQ_DONE: begin
					done_q   <= 1'b1;
					popped_q <= value_q;
					status_q <= STAT_DONE;
					occ_q    <= count_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign done         = done_q;
	assign popped_value = popped_q;
	assign status       = status_q;
	assign occupancy    = OCC_W'(occ_q);

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("queued count above capacity");

	a_fresh_ge_count: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q >= count_q)
		else $error("fewer slots handed out than queued");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && act == ACT_CLR) |=> (done && occupancy == '0 && busy))
		else $error("clear did not report an empty queue");

	a_link_not_self: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENQ_FIX) |-> (prev_q != slot_q))
		else $error("new node linked behind itself");
`endif

endmodule

FILE: rtl/gtq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
